// ----- design/wtm_pkg.sv -----
// ----------------------------------------------------------------------------
// wtm_pkg
// Shared constants, controller states and the control/status bundles of the
// windowed throughput meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wtm_pkg;

  localparam int WINDOW_SLICES     = 30;
  localparam int SLICES_PER_SECOND = 10;

  localparam int BYTES_W = 16;
  localparam int SLICE_W = 32;
  localparam int TOTAL_W = 37;
  localparam int RATE_W  = 36;
  localparam int FILL_W  = 5;

  localparam int IDX_W = $clog2(WINDOW_SLICES);
  localparam int CNT_W = $clog2(WINDOW_SLICES + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int DVD_W = TOTAL_W + $clog2(SLICES_PER_SECOND + 1);

  localparam int DIV_STEPS = DVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int IN_DATA_W  = 2 * BYTES_W;
  localparam int OUT_BITS   = 2 * RATE_W + FILL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } wtm_state_t;

  typedef struct packed {
    logic take_plain;
    logic take_clear;
    logic take_tick;
    logic update;
    logic div_init;
    logic div_step;
    logic finish;
  } wtm_cmd_t;

  typedef struct packed {
    logic out_free;
  } wtm_status_t;

endpackage

`default_nettype wire

// ----- design/wtm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wtm_ctrl
// Sequencer: takes beats, runs the slice-close update and the rate division.
// ----------------------------------------------------------------------------
`default_nettype none

module wtm_ctrl
  import wtm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tlast,
  input  logic        in_tuser,
  output logic        in_tready,
  input  wtm_status_t status,
  output wtm_cmd_t    cmd
);

  wtm_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;

  assign accept = (state_r == ST_IDLE) && in_tvalid && status.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !in_tuser && in_tlast) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: begin
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready      = status.out_free;
        cmd.take_plain = accept && !in_tuser && !in_tlast;
        cmd.take_clear = accept && in_tuser;
        cmd.take_tick  = accept && !in_tuser && in_tlast;
      end
      ST_READ:     ;
      ST_UPDATE:   cmd.update   = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_DONE:     cmd.finish   = status.out_free;
      default:     ;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/wtm_dp.sv -----
// ----------------------------------------------------------------------------
// wtm_dp
// Slice accumulators, slice rings, window totals, shared-sequence divider and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wtm_dp
  import wtm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  wtm_cmd_t              cmd,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tready,
  output wtm_status_t           status,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // ring storage
  logic [SLICE_W-1:0]       rx_ring [WINDOW_SLICES];
  logic [SLICE_W-1:0]       tx_ring [WINDOW_SLICES];
  logic [WINDOW_SLICES-1:0] vld_r, vld_nxt;
  logic [SLICE_W-1:0]       rd_rx_r, rd_tx_r;
  logic                     rd_vld_r;

  logic [IDX_W-1:0]   oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOTAL_W-1:0] rx_total_r, rx_total_nxt, tx_total_r, tx_total_nxt;
  logic [SLICE_W-1:0] rx_cur_r, rx_cur_nxt, tx_cur_r, tx_cur_nxt;
  logic [BYTES_W-1:0] rx_byte_r, tx_byte_r;

  logic [DVD_W-1:0]  rx_dvd_r, rx_dvd_nxt, tx_dvd_r, tx_dvd_nxt;
  logic [CNT_W-1:0]  rx_rem_r, rx_rem_nxt, tx_rem_r, tx_rem_nxt;
  logic [CNT_W:0]    rx_trial, tx_trial;
  logic              rx_ge, tx_ge;

  logic [RATE_W-1:0] rx_rate_r, rx_rate_nxt, tx_rate_r, tx_rate_nxt;

  logic              out_vld_r, out_vld_nxt;
  logic [RATE_W-1:0] out_rx_r, out_rx_nxt, out_tx_r, out_tx_nxt;
  logic [FILL_W-1:0] out_fill_r, out_fill_nxt;

  logic               evict;
  logic [SUM_W-1:0]   wr_sum;
  logic [IDX_W-1:0]   wr_idx;
  logic [SLICE_W-1:0] rx_sub, tx_sub;
  logic [SLICE_W:0]   rx_sat_sum, tx_sat_sum;

  assign status.out_free = !out_vld_r || out_tready;

  assign evict  = (count_r == CNT_W'(WINDOW_SLICES));
  assign wr_sum = SUM_W'(oldest_r) + SUM_W'(count_r);
  assign wr_idx = evict ? oldest_r :
                  (wr_sum >= SUM_W'(WINDOW_SLICES)) ?
                  IDX_W'(wr_sum - SUM_W'(WINDOW_SLICES)) : IDX_W'(wr_sum);
  assign rx_sub = (evict && rd_vld_r) ? rd_rx_r : '0;
  assign tx_sub = (evict && rd_vld_r) ? rd_tx_r : '0;

  assign rx_sat_sum = {1'b0, rx_cur_r} + (SLICE_W + 1)'(in_tdata[BYTES_W-1:0]);
  assign tx_sat_sum = {1'b0, tx_cur_r} + (SLICE_W + 1)'(in_tdata[2*BYTES_W-1:BYTES_W]);

  assign rx_trial = {rx_rem_r, rx_dvd_r[DVD_W-1]};
  assign tx_trial = {tx_rem_r, tx_dvd_r[DVD_W-1]};
  assign rx_ge    = rx_trial >= {1'b0, count_r};
  assign tx_ge    = tx_trial >= {1'b0, count_r};

  // window state
  always_comb begin
    vld_nxt      = vld_r;
    oldest_nxt   = oldest_r;
    count_nxt    = count_r;
    rx_total_nxt = rx_total_r;
    tx_total_nxt = tx_total_r;
    rx_cur_nxt   = rx_cur_r;
    tx_cur_nxt   = tx_cur_r;
    if (cmd.take_clear) begin
      vld_nxt      = '0;
      oldest_nxt   = '0;
      count_nxt    = CNT_W'(1);
      rx_total_nxt = '0;
      tx_total_nxt = '0;
      rx_cur_nxt   = '0;
      tx_cur_nxt   = '0;
    end else if (cmd.take_plain) begin
      rx_cur_nxt = rx_sat_sum[SLICE_W] ? '1 : rx_sat_sum[SLICE_W-1:0];
      tx_cur_nxt = tx_sat_sum[SLICE_W] ? '1 : tx_sat_sum[SLICE_W-1:0];
    end else if (cmd.update) begin
      vld_nxt[wr_idx] = 1'b1;
      rx_total_nxt    = rx_total_r + TOTAL_W'(rx_cur_r) - TOTAL_W'(rx_sub);
      tx_total_nxt    = tx_total_r + TOTAL_W'(tx_cur_r) - TOTAL_W'(tx_sub);
      rx_cur_nxt      = SLICE_W'(rx_byte_r);
      tx_cur_nxt      = SLICE_W'(tx_byte_r);
      if (evict) begin
        oldest_nxt = (oldest_r == IDX_W'(WINDOW_SLICES - 1)) ? '0 : oldest_r + IDX_W'(1);
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // divider, cached rates, output register
  always_comb begin
    rx_dvd_nxt   = rx_dvd_r;
    tx_dvd_nxt   = tx_dvd_r;
    rx_rem_nxt   = rx_rem_r;
    tx_rem_nxt   = tx_rem_r;
    rx_rate_nxt  = rx_rate_r;
    tx_rate_nxt  = tx_rate_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_rx_nxt   = out_rx_r;
    out_tx_nxt   = out_tx_r;
    out_fill_nxt = out_fill_r;
    if (cmd.div_init) begin
      rx_dvd_nxt = DVD_W'(rx_total_r) * DVD_W'(SLICES_PER_SECOND);
      tx_dvd_nxt = DVD_W'(tx_total_r) * DVD_W'(SLICES_PER_SECOND);
      rx_rem_nxt = '0;
      tx_rem_nxt = '0;
    end else if (cmd.div_step) begin
      rx_dvd_nxt = {rx_dvd_r[DVD_W-2:0], rx_ge};
      tx_dvd_nxt = {tx_dvd_r[DVD_W-2:0], tx_ge};
      rx_rem_nxt = CNT_W'(rx_ge ? rx_trial - {1'b0, count_r} : rx_trial);
      tx_rem_nxt = CNT_W'(tx_ge ? tx_trial - {1'b0, count_r} : tx_trial);
    end
    if (cmd.take_clear) begin
      rx_rate_nxt  = '0;
      tx_rate_nxt  = '0;
      out_vld_nxt  = 1'b1;
      out_rx_nxt   = '0;
      out_tx_nxt   = '0;
      out_fill_nxt = FILL_W'(1);
    end else if (cmd.take_plain) begin
      out_vld_nxt  = 1'b1;
      out_rx_nxt   = rx_rate_r;
      out_tx_nxt   = tx_rate_r;
      out_fill_nxt = FILL_W'(count_r);
    end else if (cmd.finish) begin
      rx_rate_nxt  = RATE_W'(rx_dvd_r);
      tx_rate_nxt  = RATE_W'(tx_dvd_r);
      out_vld_nxt  = 1'b1;
      out_rx_nxt   = RATE_W'(rx_dvd_r);
      out_tx_nxt   = RATE_W'(tx_dvd_r);
      out_fill_nxt = FILL_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      oldest_r   <= '0;
      count_r    <= CNT_W'(1);
      rx_total_r <= '0;
      tx_total_r <= '0;
      rx_cur_r   <= '0;
      tx_cur_r   <= '0;
      rx_rate_r  <= '0;
      tx_rate_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      oldest_r   <= oldest_nxt;
      count_r    <= count_nxt;
      rx_total_r <= rx_total_nxt;
      tx_total_r <= tx_total_nxt;
      rx_cur_r   <= rx_cur_nxt;
      tx_cur_r   <= tx_cur_nxt;
      rx_rate_r  <= rx_rate_nxt;
      tx_rate_r  <= tx_rate_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rx_dvd_r   <= rx_dvd_nxt;
    tx_dvd_r   <= tx_dvd_nxt;
    rx_rem_r   <= rx_rem_nxt;
    tx_rem_r   <= tx_rem_nxt;
    out_rx_r   <= out_rx_nxt;
    out_tx_r   <= out_tx_nxt;
    out_fill_r <= out_fill_nxt;
    if (cmd.take_tick) begin
      rx_byte_r <= in_tdata[BYTES_W-1:0];
      tx_byte_r <= in_tdata[2*BYTES_W-1:BYTES_W];
    end
  end

  // slice rings: one write port, registered read at the oldest slot
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rx_ring[wr_idx] <= rx_cur_r;
      tx_ring[wr_idx] <= tx_cur_r;
    end
    rd_rx_r  <= rx_ring[oldest_r];
    rd_tx_r  <= tx_ring[oldest_r];
    rd_vld_r <= vld_r[oldest_r];
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'({out_fill_r, out_tx_r, out_rx_r});

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CNT_W'(WINDOW_SLICES))
    else $error("slice count out of range");

  a_oldest_range: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r < IDX_W'(WINDOW_SLICES))
    else $error("oldest slot out of range");

  a_no_wrap_before_full: assert property (@(posedge clk) disable iff (!rst_n)
    !evict |-> oldest_r == '0)
    else $error("ring advanced before window filled");

  a_clear_restores: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_clear |=> (count_r == CNT_W'(1) && rx_total_r == '0 && tx_total_r == '0))
    else $error("clear did not restore window");

endmodule

`default_nettype wire

// ----- design/windowed_throughput_meter_top.sv -----
// ----------------------------------------------------------------------------
// windowed_throughput_meter_top
// Sliding-window receive/transmit throughput meter over closed time slices.
//
// Input beat:  in_tdata = received_bytes, sent_bytes; in_tlast = slice_end
//              (closes the current slice before the bytes count);
//              in_tuser = clear_all (back to one zero slice, rest ignored).
// Output beat: one per input beat, rate = window total * 10 / filled slices
//              for each direction, plus the fill count.
// Sequencing: a plain or clear beat is taken in IDLE and its result is valid
//   the next cycle. A slice-end beat holds the input through accept, ring
//   read, window update, divider load, 41 one-bit restoring division steps
//   (both directions in parallel) and the result load, which waits for a free
//   output register; no beat is taken until its result is loaded.
// Rates are held between slice ends, so plain beats reuse the last quotient.
// A stalled receiver holds the output register; a new beat is still taken
// while the held result is being taken in the same cycle.
// Reset (rst_n low, synchronous) gives an empty window of one zero slice,
// zero rates and no pending output.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_throughput_meter_top
  import wtm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // received_bytes, sent_bytes
  input  wire logic                  in_tlast,   // slice_end
  input  wire logic                  in_tuser,   // clear_all
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // download_rate, upload_rate, window_fill
);

  wtm_cmd_t    cmd;
  wtm_status_t status;

  wtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wtm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- test/tb_windowed_throughput_meter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_throughput_meter_top
// Streams byte-count beats with slice ticks and clears into the meter. A
// scoreboard class models the slice ring, the window totals and the saturating
// slice accumulators, and checks the rates and fill count of each result. The
// run covers a directed opening and random traffic with bursty input and
// receiver back-pressure.
// ----------------------------------------------------------------------------

module tb_windowed_throughput_meter_top
  import wtm_pkg::*;
();

  localparam int IDLE_LIMIT = 2000;

  class rate_scoreboard;
    typedef struct {
      bit [RATE_W-1:0] down;
      bit [RATE_W-1:0] up;
      bit [FILL_W-1:0] fill;
    } rates_t;

    bit [SLICE_W-1:0] rx_ring[WINDOW_SLICES];
    bit [SLICE_W-1:0] tx_ring[WINDOW_SLICES];
    int unsigned      oldest;
    int unsigned      filled;
    bit [63:0]        rx_total;
    bit [63:0]        tx_total;
    bit [SLICE_W-1:0] rx_slice;
    bit [SLICE_W-1:0] tx_slice;
    rates_t           pending_rates[$];
    int               errors;
    int               beats;
    int               ticks;
    int               clears;
    int               evictions;
    int               saturations;
    int               max_fill;
    int               results;

    function new();
      restart();
    endfunction

    function void restart();
      foreach (rx_ring[i]) begin
        rx_ring[i] = '0;
        tx_ring[i] = '0;
      end
      oldest   = 0;
      filled   = 1;
      rx_total = '0;
      tx_total = '0;
      rx_slice = '0;
      tx_slice = '0;
    endfunction

    function bit [SLICE_W-1:0] sat_add(bit [SLICE_W-1:0] acc, bit [BYTES_W-1:0] b);
      bit [SLICE_W:0] s;
      s = {1'b0, acc} + b;
      if (s[SLICE_W]) begin
        saturations++;
        return '1;
      end
      return s[SLICE_W-1:0];
    endfunction

    function void close_slice();
      int unsigned slot;
      rx_total += rx_slice;
      tx_total += tx_slice;
      if (filled >= WINDOW_SLICES) begin
        slot = oldest % WINDOW_SLICES;
        rx_total -= rx_ring[slot];
        tx_total -= tx_ring[slot];
        rx_ring[slot] = rx_slice;
        tx_ring[slot] = tx_slice;
        oldest = (slot + 1) % WINDOW_SLICES;
        filled = WINDOW_SLICES;
        evictions++;
      end else begin
        slot = (oldest + filled) % WINDOW_SLICES;
        rx_ring[slot] = rx_slice;
        tx_ring[slot] = tx_slice;
        filled++;
      end
      rx_slice = '0;
      tx_slice = '0;
    endfunction

    function bit [RATE_W-1:0] rate_of(bit [63:0] total);
      bit [63:0] q;
      q = (total * 64'(SLICES_PER_SECOND)) / 64'(filled);
      return q[RATE_W-1:0];
    endfunction

    function void log_event(bit tick, bit clr, bit [BYTES_W-1:0] rx, bit [BYTES_W-1:0] tx);
      rates_t r;
      beats++;
      if (clr) begin
        clears++;
        restart();
      end else begin
        if (tick) begin
          ticks++;
          close_slice();
        end
        rx_slice = sat_add(rx_slice, rx);
        tx_slice = sat_add(tx_slice, tx);
      end
      if (filled > max_fill) max_fill = filled;
      r.down = rate_of(rx_total);
      r.up   = rate_of(tx_total);
      r.fill = filled[FILL_W-1:0];
      pending_rates.push_back(r);
    endfunction

    function void check_rates(logic [OUT_DATA_W-1:0] d);
      rates_t           e;
      logic [RATE_W-1:0] down;
      logic [RATE_W-1:0] up;
      logic [FILL_W-1:0] fill;
      down = d[RATE_W-1:0];
      up   = d[2*RATE_W-1:RATE_W];
      fill = d[2*RATE_W+FILL_W-1:2*RATE_W];
      results++;
      if (pending_rates.size() == 0) begin
        $display("%0t: unexpected result beat, tdata %h", $time, d);
        errors++;
        return;
      end
      e = pending_rates.pop_front();
      if (down !== e.down) begin
        $display("%0t: download_rate expected %0d actual %0d", $time, e.down, down);
        errors++;
      end
      if (up !== e.up) begin
        $display("%0t: upload_rate expected %0d actual %0d", $time, e.up, up);
        errors++;
      end
      if (fill !== e.fill) begin
        $display("%0t: window_fill expected %0d actual %0d", $time, e.fill, fill);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // received_bytes, sent_bytes
  logic                  in_tlast;    // slice_end
  logic                  in_tuser;    // clear_all
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // download_rate, upload_rate, window_fill

  rate_scoreboard sb;
  int             idle_cycles = 0;
  int             burst_left;

  windowed_throughput_meter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // monitor: log the input beat first so a same-edge result still finds it
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.log_event(in_tlast, in_tuser, in_tdata[BYTES_W-1:0], in_tdata[2*BYTES_W-1:BYTES_W]);
      if (out_tvalid && out_tready)
        sb.check_rates(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver back-pressure: the stall mode (none, short, long) is redrawn at random
  initial begin
    int stall_left;
    int mode;
    int mode_cycles;
    out_tready  = 1'b0;
    stall_left  = 0;
    mode        = 0;
    mode_cycles = 0;
    forever begin
      @(negedge clk);
      if (mode_cycles == 0) begin
        mode        = $urandom_range(0, 2);
        mode_cycles = $urandom_range(50, 400);
      end
      mode_cycles--;
      if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if (mode == 1 && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_tready = 1'b0;
      end else if (mode == 2 && $urandom_range(0, 1) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // called at a falling edge; returns at a falling edge after acceptance and any random idle gap
  task automatic send_beat(bit tick, bit clr, bit [BYTES_W-1:0] rx, bit [BYTES_W-1:0] tx);
    int gap;
    in_tvalid = 1'b1;
    in_tlast  = tick;
    in_tuser  = clr;
    in_tdata  = {tx, rx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
  endtask

  function automatic bit [BYTES_W-1:0] pick_bytes();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BYTES_W'($urandom);
    endcase
  endfunction

  task automatic random_beat();
    int r;
    r = $urandom_range(0, 999);
    send_beat(r >= 4 && r < 170, r < 4, pick_bytes(), pick_bytes());
  endtask

  initial begin
    sb          = new();
    burst_left  = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    in_tuser    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed opening
    send_beat(1'b0, 1'b0, 16'h0000, 16'h0000);
    send_beat(1'b0, 1'b0, 16'hFFFF, 16'hFFFF);
    send_beat(1'b1, 1'b0, 16'h0000, 16'h0000);
    send_beat(1'b1, 1'b0, 16'hFFFF, 16'h0001);
    send_beat(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);  // clear ignores the rest
    send_beat(1'b1, 1'b0, 16'hAAAA, 16'h5555);
    send_beat(1'b0, 1'b1, 16'h1234, 16'h8765);
    send_beat(1'b1, 1'b0, 16'h0000, 16'h0000);
    for (int i = 0; i < 6; i++)
      send_beat(1'b1, 1'b0, (i % 2) ? 16'h5555 : 16'hAAAA, (i % 2) ? 16'hAAAA : 16'h5555);
    send_beat(1'b0, 1'b0, 16'h8000, 16'h0001);
    send_beat(1'b1, 1'b0, 16'h7FFF, 16'hFFFE);
    send_beat(1'b0, 1'b1, 16'h0000, 16'h0000);

    for (int i = 0; i < 1500; i++)
      random_beat();
    in_tvalid = 1'b0;

    while (sb.pending_rates.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Covered %0d beats: %0d slice ticks, %0d clears, %0d evictions,",
             sb.beats, sb.ticks, sb.clears, sb.evictions);
    $display("%0d saturating adds, peak window fill %0d, %0d results checked.",
             sb.saturations, sb.max_fill, sb.results);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/wtm_pkg.sv
design/wtm_ctrl.sv
design/wtm_dp.sv
design/windowed_throughput_meter_top.sv
test/tb_windowed_throughput_meter_top.sv
